>>> sv/cpse_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and command/status types of the postfix evaluator
package cpse_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DW              = 64;
    localparam int STEP_W          = $clog2(DW);

    localparam logic [1:0] KIND_NUM = 2'd0;
    localparam logic [1:0] KIND_OP  = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MOD = 3'd4;
    localparam logic [2:0] OP_SHR = 3'd5;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_FEW       = 4'd1;
    localparam logic [3:0] ST_INVALID   = 4'd2;
    localparam logic [3:0] ST_ADD_OVF   = 4'd3;
    localparam logic [3:0] ST_SUB_OVF   = 4'd4;
    localparam logic [3:0] ST_MUL_OVF   = 4'd5;
    localparam logic [3:0] ST_DIV0      = 4'd6;
    localparam logic [3:0] ST_DIV_OVF   = 4'd7;
    localparam logic [3:0] ST_MOD0      = 4'd8;
    localparam logic [3:0] ST_MOD_OVF   = 4'd9;
    localparam logic [3:0] ST_NEG_SHIFT = 4'd10;
    localparam logic [3:0] ST_BIG_SHIFT = 4'd11;
    localparam logic [3:0] ST_FULL      = 4'd12;

    localparam logic [1:0] WSEL_PUSH = 2'd0;
    localparam logic [1:0] WSEL_IMM  = 2'd1;
    localparam logic [1:0] WSEL_ITER = 2'd2;

    typedef struct packed {
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       lat_r;
        logic       lat_l;
        logic       start;
        logic       step;
        logic       load_out;
        logic       out_ok;
        logic [2:0] op;
    } cpse_cmd_t;

    typedef struct packed {
        logic [3:0] imm_err;
        logic [3:0] fin_err;
        logic       iter_last;
    } cpse_stat_t;

endpackage

>>> sv/cpse_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module cpse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/cpse_datapath.sv
`timescale 1ns / 1ps
// operand stack, alu, shared shift-add/subtract unit and result register
module cpse_datapath
    import cpse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  logic          aclk,
    input  cpse_cmd_t     cmd,
    input  logic [AW-1:0] rd_addr,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] push_value,
    output cpse_stat_t    stat,
    output logic [DW-1:0] out_result
);

    logic [DW-1:0] rdata;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] l_reg, r_reg, acc_reg, sh_reg, mc_reg, result_reg;
    logic [STEP_W-1:0] step_reg;

    logic [DW-1:0] sum, dif, ml, mr, imm_res, fin_res, shifted;
    logic [DW:0]   msum, ddif;
    logic          neg, mul_ovf;
    logic [3:0]    imm_err, fin_err;

    cpse_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_comb begin
        sum     = l_reg + r_reg;
        dif     = l_reg - r_reg;
        neg     = l_reg[DW-1] ^ r_reg[DW-1];
        ml      = l_reg[DW-1] ? (~l_reg + 1'b1) : l_reg;
        mr      = r_reg[DW-1] ? (~r_reg + 1'b1) : r_reg;
        imm_err = ST_OK;
        imm_res = sum;
        unique case (cmd.op)
            OP_ADD: begin
                if ((l_reg[DW-1] == r_reg[DW-1]) && (sum[DW-1] != l_reg[DW-1])) begin
                    imm_err = ST_ADD_OVF;
                end
            end
            OP_SUB: begin
                imm_res = dif;
                if ((l_reg[DW-1] != r_reg[DW-1]) && (dif[DW-1] != l_reg[DW-1])) begin
                    imm_err = ST_SUB_OVF;
                end
            end
            OP_DIV: begin
                if (r_reg == '0) begin
                    imm_err = ST_DIV0;
                end else if (l_reg == {1'b1, {(DW-1){1'b0}}} && r_reg == '1) begin
                    imm_err = ST_DIV_OVF;
                end
            end
            OP_MOD: begin
                if (r_reg == '0) begin
                    imm_err = ST_MOD0;
                end else if (l_reg == {1'b1, {(DW-1){1'b0}}} && r_reg == '1) begin
                    imm_err = ST_MOD_OVF;
                end
            end
            OP_SHR: begin
                imm_res = $signed(l_reg) >>> r_reg[STEP_W-1:0];
                if (r_reg[DW-1]) begin
                    imm_err = ST_NEG_SHIFT;
                end else if (|r_reg[DW-2:STEP_W]) begin
                    imm_err = ST_BIG_SHIFT;
                end
            end
            default: ;
        endcase
    end

    // one multiplier bit or one quotient bit per step
    always_comb begin
        msum    = {1'b0, acc_reg} + {1'b0, (sh_reg[0] ? mc_reg : {DW{1'b0}})};
        shifted = {acc_reg[DW-2:0], sh_reg[DW-1]};
        ddif    = {1'b0, shifted} - {1'b0, mc_reg};
        mul_ovf = (|acc_reg) || (sh_reg[DW-1] && (!neg || (|sh_reg[DW-2:0])));
        fin_err = ST_OK;
        fin_res = neg ? (~sh_reg + 1'b1) : sh_reg;
        case (cmd.op)
            OP_MUL: begin
                if (mul_ovf) begin
                    fin_err = ST_MUL_OVF;
                end
            end
            OP_MOD: begin
                fin_res = (l_reg[DW-1] && (|acc_reg)) ? (mr - acc_reg) : acc_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.lat_r) begin
            r_reg <= rdata;
        end
        if (cmd.lat_l) begin
            l_reg <= rdata;
        end
        if (cmd.start) begin
            acc_reg  <= '0;
            sh_reg   <= ml;
            mc_reg   <= mr;
            step_reg <= '1;
        end else if (cmd.step) begin
            step_reg <= step_reg - 1'b1;
            if (cmd.op == OP_MUL) begin
                acc_reg <= msum[DW:1];
                sh_reg  <= {msum[0], sh_reg[DW-1:1]};
            end else if (!ddif[DW]) begin
                acc_reg <= ddif[DW-1:0];
                sh_reg  <= {sh_reg[DW-2:0], 1'b1};
            end else begin
                acc_reg <= shifted;
                sh_reg  <= {sh_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.load_out) begin
            result_reg <= cmd.out_ok ? rdata : '0;
        end
    end

    always_comb begin
        case (cmd.wr_sel)
            WSEL_IMM:  wr_data = imm_res;
            WSEL_ITER: wr_data = fin_res;
            default:   wr_data = push_value;
        endcase
    end

    assign stat.imm_err   = imm_err;
    assign stat.fin_err   = fin_err;
    assign stat.iter_last = (step_reg == '0);
    assign out_result     = result_reg;

endmodule

>>> sv/cpse_ctrl.sv
`timescale 1ns / 1ps
// token sequencer: stack count, error latch, handshakes and datapath commands
module cpse_ctrl
    import cpse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    localparam int AW = $clog2(STACK_DEPTH),
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_kind,
    input  logic [2:0]    s_op,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [3:0]    m_status,
    output cpse_cmd_t     cmd,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr,
    input  cpse_stat_t    stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD_L   = 3'd1;
    localparam logic [2:0] S_LOAD_L = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_ITER   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;
    localparam logic [2:0] S_END    = 3'd6;

    localparam logic [CW-1:0] FULL_C = CW'(STACK_DEPTH);

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    err_reg, err_next;
    logic [2:0]    op_reg, op_next;
    logic          mvalid_reg, mvalid_next;
    logic [3:0]    status_reg, status_next;
    logic [CW-1:0] cnt_m1, cnt_m2;
    logic          accept;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign cnt_m1  = count_reg - CW'(1);
    assign cnt_m2  = count_reg - CW'(2);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        err_next    = err_reg;
        op_next     = op_reg;
        mvalid_next = mvalid_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.op      = op_reg;
        rd_addr     = cnt_m1[AW-1:0];
        wr_addr     = count_reg[AW-1:0];
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_kind == KIND_END) begin
                    rd_addr = '0;
                end
                if (accept) begin
                    case (s_kind)
                        KIND_NUM: begin
                            if (err_reg == ST_OK) begin
                                if (count_reg >= FULL_C) begin
                                    err_next = ST_FULL;
                                end else begin
                                    cmd.wr_en  = 1'b1;
                                    cmd.wr_sel = WSEL_PUSH;
                                    count_next = count_reg + CW'(1);
                                end
                            end
                        end
                        KIND_OP: begin
                            if (err_reg == ST_OK) begin
                                if (count_reg < CW'(2)) begin
                                    err_next = ST_FEW;
                                end else if (s_op <= OP_SHR) begin
                                    op_next    = s_op;
                                    state_next = S_RD_L;
                                end
                            end
                        end
                        KIND_END: begin
                            state_next = S_END;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_L: begin
                cmd.lat_r  = 1'b1;
                rd_addr    = cnt_m2[AW-1:0];
                state_next = S_LOAD_L;
            end
            S_LOAD_L: begin
                cmd.lat_l  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (stat.imm_err != ST_OK) begin
                    err_next   = stat.imm_err;
                    count_next = cnt_m2;
                    state_next = S_IDLE;
                end else if (op_reg == OP_MUL || op_reg == OP_DIV || op_reg == OP_MOD) begin
                    cmd.start  = 1'b1;
                    state_next = S_ITER;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WSEL_IMM;
                    wr_addr    = cnt_m2[AW-1:0];
                    count_next = cnt_m1;
                    state_next = S_IDLE;
                end
            end
            S_ITER: begin
                cmd.step = 1'b1;
                if (stat.iter_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (stat.fin_err != ST_OK) begin
                    err_next   = stat.fin_err;
                    count_next = cnt_m2;
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WSEL_ITER;
                    wr_addr    = cnt_m2[AW-1:0];
                    count_next = cnt_m1;
                end
                state_next = S_IDLE;
            end
            S_END: begin
                rd_addr = '0;
                if (!mvalid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    cmd.out_ok   = (err_reg == ST_OK) && (count_reg == CW'(1));
                    if (err_reg != ST_OK) begin
                        status_next = err_reg;
                    end else if (count_reg != CW'(1)) begin
                        status_next = ST_INVALID;
                    end else begin
                        status_next = ST_OK;
                    end
                    mvalid_next = 1'b1;
                    count_next  = '0;
                    err_next    = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            err_reg    <= ST_OK;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            err_reg    <= err_next;
            mvalid_reg <= mvalid_next;
        end
        op_reg     <= op_next;
        status_reg <= status_next;
    end

    assign m_valid  = mvalid_reg;
    assign m_status = status_reg;

endmodule

>>> sv/checked_postfix_stack_evaluator_core.sv
`timescale 1ns / 1ps
// top level of the checked postfix evaluator
// A number or ignored token is handled in the sequencer's idle state (an end token also passes
// through an end state to read the stack and load the output register); add, sub and shift take
// two stack reads and an execute state; mul, div and mod also run the shared 64-step
// shift-add/restoring-subtract unit and a finish state. One request is worked on at a time;
// a finished result waits in the output register while the next requests are taken.
module checked_postfix_stack_evaluator_core
    import cpse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [63:0] s_value,
    input  logic [2:0]         s_op,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_result,
    output logic [3:0]         m_status
);

    localparam int AW = $clog2(STACK_DEPTH);

    cpse_cmd_t     cmd;
    cpse_stat_t    stat;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [DW-1:0] out_result;

    cpse_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_kind   (s_kind),
        .s_op     (s_op),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .stat     (stat)
    );

    cpse_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .push_value (s_value),
        .stat       (stat),
        .out_result (out_result)
    );

    assign m_result = out_result;

endmodule

>>> sv/cpse_checker.sv
`timescale 1ns / 1ps
// port-level assertions for the postfix evaluator and their bind
module cpse_checker
    import cpse_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_kind,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [63:0] m_result,
    input logic [3:0]         m_status
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result) && $stable(m_status))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_result == '0)
        else $error("nonzero result with error status");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_kind != KIND_END && !m_valid |=> !m_valid)
        else $error("result without end request");

endmodule

bind checked_postfix_stack_evaluator_core cpse_checker u_chk (.*);

>>> tb/sv/cpse_checker.sv
`timescale 1ns / 1ps
// checker for the postfix evaluator: watches both channels, predicts results and compares them
module cpse_scoreboard
    import cpse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [63:0] s_value,
    input  logic [2:0]         s_op,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [63:0] m_result,
    input  logic [3:0]         m_status,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count,
    output int                 ok_count
);

    typedef struct packed {
        logic [63:0] result;
        logic [3:0]  status;
    } answer_t;

    logic [63:0] operands [STACK_DEPTH];
    int          depth_used;
    logic [3:0]  first_err;
    answer_t     answers_due [$];

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] abs64(logic [63:0] u);
        return u[63] ? (64'd0 - u) : u;
    endfunction

    // computes l op r, returns an error code or ST_OK
    function automatic logic [3:0] calc(input logic [2:0] op, input logic [63:0] l,
                                        input logic [63:0] r, output logic [63:0] res);
        logic [63:0]  t;
        logic [127:0] prod;
        logic         neg;
        res = '0;
        case (op)
            OP_ADD: begin
                t = l + r;
                if (((l ^ t) & (r ^ t)) & MIN64) return ST_ADD_OVF;
                res = t;
            end
            OP_SUB: begin
                t = l - r;
                if (((l ^ r) & (l ^ t)) & MIN64) return ST_SUB_OVF;
                res = t;
            end
            OP_MUL: begin
                neg = l[63] ^ r[63];
                prod = abs64(l) * abs64(r);
                if (neg ? (prod > {64'd0, MIN64}) : (prod > {64'd0, MIN64 - 64'd1}))
                    return ST_MUL_OVF;
                res = neg ? (64'd0 - prod[63:0]) : prod[63:0];
            end
            OP_DIV: begin
                if (r == 0) return ST_DIV0;
                if (l == MIN64 && r == '1) return ST_DIV_OVF;
                res = $signed(l) / $signed(r);
            end
            OP_MOD: begin
                if (r == 0) return ST_MOD0;
                if (l == MIN64 && r == '1) return ST_MOD_OVF;
                t = $signed(l) % $signed(r);
                if (t[63]) t = t + abs64(r);
                res = t;
            end
            default: begin
                if (r[63]) return ST_NEG_SHIFT;
                if (r >= 64) return ST_BIG_SHIFT;
                res = $signed(l) >>> r[5:0];
            end
        endcase
        return ST_OK;
    endfunction

    task automatic take_request(logic [1:0] kind, logic [63:0] value, logic [2:0] op);
        logic [63:0] res;
        logic [3:0]  e;
        answer_t     a;
        case (kind)
            KIND_NUM: begin
                if (first_err == ST_OK) begin
                    if (depth_used >= STACK_DEPTH) first_err = ST_FULL;
                    else begin
                        operands[depth_used] = value;
                        depth_used++;
                    end
                end
            end
            KIND_OP: begin
                if (first_err == ST_OK) begin
                    if (depth_used < 2) first_err = ST_FEW;
                    else if (op <= OP_SHR) begin
                        e = calc(op, operands[depth_used-2], operands[depth_used-1], res);
                        depth_used -= 2;
                        if (e != ST_OK) first_err = e;
                        else begin
                            operands[depth_used] = res;
                            depth_used++;
                        end
                    end
                end
            end
            KIND_END: begin
                a.result = '0;
                if (first_err != ST_OK) a.status = first_err;
                else if (depth_used != 1) a.status = ST_INVALID;
                else begin
                    a.status = ST_OK;
                    a.result = operands[0];
                end
                answers_due.push_back(a);
                depth_used = 0;
                first_err = ST_OK;
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        answer_t a;
        if (!aresetn) begin
            depth_used = 0;
            first_err = ST_OK;
            answers_due.delete();
            fail_count = 0;
            result_count = 0;
            ok_count = 0;
        end else begin
            if (s_valid && s_ready) take_request(s_kind, s_value, s_op);
            if (m_valid && m_ready) begin
                result_count++;
                if (answers_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: unexpected result %0d status %0d",
                                 m_result, m_status);
                end else begin
                    a = answers_due.pop_front();
                    if (a.status == ST_OK) ok_count++;
                    if (a.result !== m_result || a.status !== m_status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %0d/%0d, got %0d/%0d",
                                     $signed(a.result), a.status, m_result, m_status);
                    end
                end
            end
        end
        pending_count = answers_due.size();
    end

    initial begin
        fail_count = 0;
        pending_count = 0;
        result_count = 0;
        ok_count = 0;
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top for the postfix evaluator: stimulus, receiver stalls and verdict
module tb_top;
    import cpse_pkg::*;

    localparam int DEPTH       = STACK_DEPTH_DEF;
    localparam int IDLE_LIMIT  = 20000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind = KIND_END;
    logic signed [63:0] s_value = '0;
    logic [2:0]         s_op = OP_ADD;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [63:0] m_result;
    logic [3:0]         m_status;

    int  fail_count, pending_count, result_count, ok_count;
    int  requests_sent = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_off = 1'b0;
    bit  timed_out = 1'b0;

    always #5 aclk = ~aclk;

    checked_postfix_stack_evaluator_core #(.STACK_DEPTH(DEPTH)) dut (.*);

    cpse_scoreboard #(.STACK_DEPTH(DEPTH)) chk (.*);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver with random stalls
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(negedge aclk);
            m_ready <= !hold_off && (calm || $urandom_range(99) >= 25);
        end
    end

    function automatic logic [63:0] rand64();
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return '1;
            3: return 64'(signed'($urandom_range(20)) - 10);
            4: return 64'($urandom_range(63));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send(logic [1:0] kind, logic [63:0] value, logic [2:0] op);
        while (!calm && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_value <= value;
        s_op <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic num(logic [63:0] v);
        send(KIND_NUM, v, 3'($urandom_range(7)));
    endtask

    task automatic oper(logic [2:0] op);
        send(KIND_OP, {$urandom(), $urandom()}, op);
    endtask

    task automatic fin();
        send(KIND_END, {$urandom(), $urandom()}, 3'($urandom_range(7)));
    endtask

    task automatic binary(logic [63:0] l, logic [63:0] r, logic [2:0] op);
        num(l);
        num(r);
        oper(op);
        fin();
    endtask

    // random well-formed expression, sometimes broken
    task automatic random_expr();
        int n;
        int live;
        n = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 2) : $urandom_range(1, 6);
        live = 0;
        for (int i = 0; i < n; i++) begin
            num(rand64());
            live++;
            while (live >= 2 && $urandom_range(2) == 0) begin
                oper($urandom_range(9) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(5)));
                live--;
            end
        end
        while (live >= 2) begin
            oper(3'($urandom_range(5)));
            live--;
        end
        case ($urandom_range(9))
            0: oper(3'($urandom_range(7)));
            1: send(2'd3, rand64(), 3'($urandom_range(7)));
            2: num(rand64());
            default: ;
        endcase
        fin();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        binary(64'h7fff_ffff_ffff_ffff, 64'd1, OP_ADD);
        binary(64'h8000_0000_0000_0000, 64'd1, OP_SUB);
        binary(64'h4000_0000_0000_0000, 64'd2, OP_MUL);
        binary(-64'sd7, 64'sd2, OP_DIV);
        binary(-64'sd7, 64'sd2, OP_MOD);
        binary(64'h8000_0000_0000_0000, '1, OP_DIV);
        binary(64'h8000_0000_0000_0000, '1, OP_MOD);
        binary(64'd5, 64'd0, OP_DIV);
        binary(64'd5, 64'd0, OP_MOD);
        binary(-64'sd256, 64'd4, OP_SHR);
        binary(64'd1, '1, OP_SHR);
        binary(64'd1, 64'd64, OP_SHR);
        binary(64'd3, 64'd4, 3'd6);
        num(64'd1);
        oper(OP_ADD);
        fin();
        fin();
        send(2'd3, 64'd0, OP_ADD);
        for (int i = 0; i <= DEPTH; i++) num(64'(i));
        fin();

        // receiver holds off while the sender keeps going
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++) binary(rand64(), rand64(), 3'($urandom_range(5)));
        join

        while (requests_sent < 1600) begin
            calm = (requests_sent >= 700 && requests_sent < 900);
            random_expr();
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        $display("sent %0d requests, checked %0d results (%0d with status ok)",
                 requests_sent, result_count, ok_count);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
